// ----- src/mfp_pkg.sv -----
`timescale 1ns / 1ps

package mfp_pkg;

   localparam int WORD_W = 32;
   localparam int REG_W  = 5;
   localparam int CNT_W  = 2;

   // match patterns for the register jump forms
   localparam logic [WORD_W-1:0] JMP_MASK     = 32'hfffffbe0;
   localparam logic [WORD_W-1:0] JMP_MATCH    = 32'hf400c000;
   localparam logic [WORD_W-1:0] JSR_MATCH    = 32'hf400c800;
   localparam logic [WORD_W-1:0] JANY_MASK    = 32'hfffff3e0;
   localparam logic [WORD_W-1:0] RET_MASK     = 32'hfffffbff;
   localparam logic [WORD_W-1:0] RET_MATCH    = 32'hf400c001;
   localparam logic [WORD_W-1:0] JDLY_MASK    = 32'hfffff7e0;
   localparam logic [WORD_W-1:0] JDLY_MATCH   = 32'hf400c400;
   // register-form load and store patterns
   localparam logic [WORD_W-1:0] LDR_MASK     = 32'hf400c0e0;
   localparam logic [WORD_W-1:0] LDR_MATCH    = 32'hf4000000;
   localparam logic [WORD_W-1:0] STR_MASK     = 32'h0000d0e0;

   // major opcode fields
   localparam logic [4:0] OP5_BR    = 5'h18;
   localparam logic [4:0] OP5_BSR   = 5'h19;
   localparam logic [4:0] OP5_BB0   = 5'h1a;
   localparam logic [4:0] OP5_BB1   = 5'h1b;
   localparam logic [4:0] OP5_BCND  = 5'h1d;
   localparam logic [3:0] OP4_BRBSR = 4'hc;
   localparam logic [5:0] OP6_BRN   = 6'h31;
   localparam logic [5:0] OP6_BSRN  = 6'h33;
   localparam logic [5:0] OP6_BB0N  = 6'h35;
   localparam logic [5:0] OP6_BB1N  = 6'h37;
   localparam logic [5:0] OP6_BCNDN = 6'h3b;
   localparam logic [5:0] OP6_REG   = 6'h3d;
   localparam logic [5:0] OP6_LD_HI = 6'h07;
   localparam logic [5:0] OP6_ST_HI = 6'h0b;

   // size codes for loads and stores
   localparam logic [3:0] SZ_LD_HI  = 4'h7;
   localparam logic [3:0] SZ_LD_D   = 4'h4;
   localparam logic [3:0] SZ_XMBU   = 4'h0;
   localparam logic [3:0] SZ_XM     = 4'h1;
   localparam logic [3:0] SZ_ST_D   = 4'h8;
   localparam logic [3:0] SZ_ST     = 4'h9;
   localparam logic [3:0] SZ_ST_H   = 4'ha;
   localparam logic [3:0] SZ_ST_B   = 4'hb;

   localparam logic [CNT_W-1:0] WORDS_NONE = 2'd0;
   localparam logic [CNT_W-1:0] WORDS_ONE  = 2'd1;
   localparam logic [CNT_W-1:0] WORDS_TWO  = 2'd2;

   typedef struct packed {
      logic [WORD_W-1:0] instr_word;
      logic [WORD_W-1:0] instr_address;
      logic [WORD_W-1:0] source_reg_value;
   } req_type;

   typedef struct packed {
      logic is_branch;
      logic is_call;
      logic is_return;
      logic is_unconditional;
      logic has_delay_slot;
   } flags_type;

   // after decode: target still split into base and offset
   typedef struct packed {
      flags_type         flags;
      logic [CNT_W-1:0]  load_words;
      logic [CNT_W-1:0]  store_words;
      logic [WORD_W-1:0] base;
      logic [WORD_W-1:0] offset;
      logic              target_valid;
      logic [REG_W-1:0]  target_reg_index;
   } dec_type;

   typedef struct packed {
      flags_type         flags;
      logic [CNT_W-1:0]  load_words;
      logic [CNT_W-1:0]  store_words;
      logic [WORD_W-1:0] target_address;
      logic              target_valid;
      logic [REG_W-1:0]  target_reg_index;
   } rsp_type;

   function automatic logic [CNT_W-1:0] load_size_words(input logic [3:0] code);
      logic [CNT_W-1:0] n;
      if (code > SZ_LD_HI) n = WORDS_NONE;
      else if (code == SZ_LD_D) n = WORDS_TWO;
      else n = WORDS_ONE;
      return n;
   endfunction

   function automatic logic [CNT_W-1:0] store_size_words(input logic [3:0] code);
      logic [CNT_W-1:0] n;
      unique case (code)
         SZ_XMBU, SZ_XM, SZ_ST, SZ_ST_H, SZ_ST_B: n = WORDS_ONE;
         SZ_ST_D:                                 n = WORDS_TWO;
         default:                                 n = WORDS_NONE;
      endcase
      return n;
   endfunction

endpackage

// ----- src/mfp_req_if.sv -----
`timescale 1ns / 1ps

interface mfp_req_if import mfp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] instr_word;
   logic [WORD_W-1:0] instr_address;
   logic [WORD_W-1:0] source_reg_value;

   modport source(output valid, output instr_word, output instr_address,
                  output source_reg_value, input ready);
   modport sink(input valid, input instr_word, input instr_address,
                input source_reg_value, output ready);
endinterface

// ----- src/mfp_rsp_if.sv -----
`timescale 1ns / 1ps

interface mfp_rsp_if import mfp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              is_branch;
   logic              is_call;
   logic              is_return;
   logic              is_unconditional;
   logic              has_delay_slot;
   logic [CNT_W-1:0]  load_words;
   logic [CNT_W-1:0]  store_words;
   logic [WORD_W-1:0] target_address;
   logic              target_valid;
   logic [REG_W-1:0]  target_reg_index;

   modport source(output valid, output is_branch, output is_call, output is_return,
                  output is_unconditional, output has_delay_slot, output load_words,
                  output store_words, output target_address, output target_valid,
                  output target_reg_index, input ready);
   modport sink(input valid, input is_branch, input is_call, input is_return,
                input is_unconditional, input has_delay_slot, input load_words,
                input store_words, input target_address, input target_valid,
                input target_reg_index, output ready);
endinterface

// ----- src/m88k_flow_and_memory_predecode_unit.sv -----
`timescale 1ns / 1ps

// channel  dir  beat
// req      in   instr_word, instr_address, source_reg_value
// rsp      out  flow flags, load/store word counts, target, target_valid, reg index
//
// three register stages: decode, target add, output register
// rsp.valid follows the accepting req edge through the decode, target add and output
// registers in turn; one beat per cycle sustained while rsp.ready stays high
// the 32-bit target add has a stage of its own; decode sets the first stage
// synchronous active-high reset empties every stage; no state kept between beats
// a stalled rsp holds; ready ripples back so bubbles in the pipe still fill

module m88k_flow_and_memory_predecode_unit import mfp_pkg::*; (
   input logic   clock,
   input logic   reset,
   mfp_req_if.sink   req,
   mfp_rsp_if.source rsp
);

   req_type req_data;
   logic    dec_valid, dec_ready;
   dec_type dec_data;
   logic    tgt_valid, tgt_ready;
   rsp_type tgt_data;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   logic    out_ready;

   assign req_data.instr_word       = req.instr_word;
   assign req_data.instr_address    = req.instr_address;
   assign req_data.source_reg_value = req.source_reg_value;

   // stage 1: opcode decode, size counts, target operands
   mfp_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_data   (req_data),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   // stage 2: target add
   mfp_target u_target (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (tgt_valid),
      .out_ready (tgt_ready),
      .out_data  (tgt_data)
   );

   // stage 3: output register, free slot or taken beat lets stage 2 move
   assign out_ready = !rsp_valid_ff || rsp.ready;
   assign tgt_ready = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= tgt_valid;
      end
      if (out_ready && tgt_valid) begin
         rsp_ff <= tgt_data;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.is_branch        = rsp_ff.flags.is_branch;
   assign rsp.is_call          = rsp_ff.flags.is_call;
   assign rsp.is_return        = rsp_ff.flags.is_return;
   assign rsp.is_unconditional = rsp_ff.flags.is_unconditional;
   assign rsp.has_delay_slot   = rsp_ff.flags.has_delay_slot;
   assign rsp.load_words       = rsp_ff.load_words;
   assign rsp.store_words      = rsp_ff.store_words;
   assign rsp.target_address   = rsp_ff.target_address;
   assign rsp.target_valid     = rsp_ff.target_valid;
   assign rsp.target_reg_index = rsp_ff.target_reg_index;

`ifndef ASSERT_OFF
   // no target means zero address and zero register index
   a_no_target_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.target_valid |->
         rsp_ff.target_address == '0 && rsp_ff.target_reg_index == '0)
      else $error("target fields not cleared without a target");

   // a transfer with a target is a branch or a call, never both
   a_target_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.target_valid |->
         $onehot({rsp_ff.flags.is_branch, rsp_ff.flags.is_call}))
      else $error("target without exactly one of branch and call");

   // word counts never exceed two
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.load_words != 2'd3 && rsp_ff.store_words != 2'd3)
      else $error("word count out of range");

   // a beat held in the adder stage under stall is still there next cycle
   a_hold_target: assert property (@(posedge clock) disable iff (reset)
      tgt_valid && !tgt_ready |=> tgt_valid && $stable(tgt_data))
      else $error("adder stage beat lost under stall");

   // a beat held in decode under stall is still there next cycle
   a_hold_decode: assert property (@(posedge clock) disable iff (reset)
      dec_valid && !dec_ready |=> dec_valid && $stable(dec_data))
      else $error("decode stage beat lost under stall");
`endif

endmodule

// ----- src/mfp_decode.sv -----
`timescale 1ns / 1ps

module mfp_decode import mfp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output dec_type out_data
);

   logic              dec_valid_ff;
   dec_type           dec_ff;
   dec_type           dec_in;
   logic [WORD_W-1:0] w;
   logic [4:0]        top5;
   logic [5:0]        top6;
   logic              jmp, jsr, jany, br_bsr, cond;

   always_comb begin
      w      = in_data.instr_word;
      top5   = w[31:27];
      top6   = w[31:26];
      jmp    = (w & JMP_MASK) == JMP_MATCH;
      jsr    = (w & JMP_MASK) == JSR_MATCH;
      jany   = (w & JANY_MASK) == JMP_MATCH;
      br_bsr = w[31:28] == OP4_BRBSR;
      cond   = (top5 == OP5_BB0) || (top5 == OP5_BB1) || (top5 == OP5_BCND);

      dec_in.flags.is_branch        = (top5 == OP5_BR) || cond || jmp;
      dec_in.flags.is_call          = (top5 == OP5_BSR) || jsr;
      dec_in.flags.is_return        = (w & RET_MASK) == RET_MATCH;
      dec_in.flags.is_unconditional = br_bsr || jany;
      dec_in.flags.has_delay_slot   = (top6 == OP6_BRN) || (top6 == OP6_BSRN) ||
                                      (top6 == OP6_BB0N) || (top6 == OP6_BB1N) ||
                                      (top6 == OP6_BCNDN) ||
                                      ((w & JDLY_MASK) == JDLY_MATCH);

      // loads: immediate forms by opcode, register form by size field
      if (top6 <= OP6_LD_HI)
         dec_in.load_words = load_size_words(top6[3:0]);
      else if (top6 == OP6_REG && (w & LDR_MASK) == LDR_MATCH)
         dec_in.load_words = load_size_words(w[13:10]);
      else
         dec_in.load_words = WORDS_NONE;

      if (top6 <= OP6_ST_HI)
         dec_in.store_words = store_size_words(top6[3:0]);
      else if (top6 == OP6_REG && (w & STR_MASK) == '0)
         dec_in.store_words = store_size_words(w[13:10]);
      else
         dec_in.store_words = WORDS_NONE;

      dec_in.target_reg_index = '0;
      priority if (br_bsr) begin
         dec_in.base         = in_data.instr_address;
         dec_in.offset       = {{4{w[25]}}, w[25:0], 2'b00};
         dec_in.target_valid = 1'b1;
      end else if (cond) begin
         dec_in.base         = in_data.instr_address;
         dec_in.offset       = {{14{w[15]}}, w[15:0], 2'b00};
         dec_in.target_valid = 1'b1;
      end else if (jany) begin
         dec_in.base             = in_data.source_reg_value;
         dec_in.offset           = '0;
         dec_in.target_valid     = 1'b1;
         dec_in.target_reg_index = w[REG_W-1:0];
      end else begin
         dec_in.base         = '0;
         dec_in.offset       = '0;
         dec_in.target_valid = 1'b0;
      end
   end

   assign in_ready  = !dec_valid_ff || out_ready;
   assign out_valid = dec_valid_ff;
   assign out_data  = dec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else if (in_ready) begin
         dec_valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         dec_ff <= dec_in;
      end
   end

endmodule

// ----- src/mfp_target.sv -----
`timescale 1ns / 1ps

module mfp_target import mfp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  dec_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    tgt_valid_ff;
   rsp_type tgt_ff;
   rsp_type tgt_in;

   always_comb begin
      tgt_in.flags            = in_data.flags;
      tgt_in.load_words       = in_data.load_words;
      tgt_in.store_words      = in_data.store_words;
      tgt_in.target_address   = in_data.base + in_data.offset;   // wraps mod 2^32
      tgt_in.target_valid     = in_data.target_valid;
      tgt_in.target_reg_index = in_data.target_reg_index;
   end

   assign in_ready  = !tgt_valid_ff || out_ready;
   assign out_valid = tgt_valid_ff;
   assign out_data  = tgt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_valid_ff <= 1'b0;
      end else if (in_ready) begin
         tgt_valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         tgt_ff <= tgt_in;
      end
   end

endmodule
